// ----- design/pgd_pkg.sv -----
// Package for the polar Gaussian deviate block.
// Holds the datapath command encoding, status struct and shared width helpers.
// No dependencies.
package pgd_pkg;

  // Fraction bits of the log2 iteration and of the Q1.30 constant
  localparam int LOG_FRAC = 30;
  localparam int Z_W      = LOG_FRAC + 1;
  localparam int OUT_W    = 30;
  localparam int P_W      = 33;
  localparam int DIV_STEPS = P_W;
  localparam int LOG_STEPS = LOG_FRAC;
  localparam logic [Z_W-1:0] TWO_LN2_Q30 = 31'd1488522236;

  // Commands from the controller to the datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQ1,
    CMD_SQ2,
    CMD_SUM,
    CMD_NINIT,
    CMD_NORM,
    CMD_ZINIT,
    CMD_LOG,
    CMD_W1,
    CMD_W2,
    CMD_DIVI,
    CMD_DIV,
    CMD_MUL1,
    CMD_MUL2,
    CMD_SQI,
    CMD_SQRT,
    CMD_SPARE,
    CMD_OUT_RES,
    CMD_OUT_SPARE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    second;  // working on the second component (the result)
  } dp_cmd_t;

  typedef struct packed {
    logic reject;     // radius squared is zero or not below one
  } dp_stat_t;

  // Steps of the leading-zero binary search over the 2*UW-bit sum
  function automatic int norm_steps(int uw);
    return $clog2(2 * uw);
  endfunction

  // Width of w = -2 ln s (s the radius squared) in Q.30
  function automatic int w_width(int uw);
    return LOG_FRAC + 1 + norm_steps(uw) + 1;
  endfunction

  // Root bits of the square root operand
  function automatic int root_bits(int uw, int ff);
    int qw;
    qw = w_width(uw) + P_W;
    if (2 * ff > 62) qw = qw + 2 * ff - 62;
    return (qw + 1) / 2;
  endfunction

endpackage

// ----- design/pgd_if.sv -----
// Stream interfaces of the polar Gaussian deviate block.
// Valid/ready handshake; does not use pgd_pkg, the result is 30 bits wide.
interface pgd_in_if #(parameter int UNIFORM_BITS = 24);
  logic                    valid;
  logic                    ready;
  logic [UNIFORM_BITS-1:0] uniform_a;
  logic [UNIFORM_BITS-1:0] uniform_b;
  modport source (output valid, output uniform_a, output uniform_b, input ready);
  modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface pgd_out_if;
  logic              valid;
  logic              ready;
  logic signed [29:0] deviate;
  modport source (output valid, output deviate, input ready);
  modport sink   (input valid, input deviate, output ready);
endinterface

// ----- design/pgd_datapath.sv -----
// Datapath of the polar Gaussian deviate block: squares, normalize, log2,
// restoring divide, split multiply and digit-by-digit square root. Uses pgd_pkg.
module pgd_datapath #(
  parameter int UNIFORM_BITS  = 24,
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic [UNIFORM_BITS-1:0]            uniform_a,
  input  logic [UNIFORM_BITS-1:0]            uniform_b,
  input  pgd_pkg::dp_cmd_t                   cmd,
  output pgd_pkg::dp_stat_t                  stat,
  output logic signed [pgd_pkg::OUT_W-1:0]   deviate
);
  import pgd_pkg::*;

  localparam int UW  = UNIFORM_BITS;
  localparam int SW  = 2 * UW;
  localparam int NS  = norm_steps(UW);
  localparam int TW  = LOG_FRAC + NS + 1;
  localparam int WW  = w_width(UW);
  localparam int QW  = WW + P_W;
  localparam int RB  = root_bits(UW, OUT_FRAC_BITS);
  localparam int SQW = 2 * RB;
  localparam int RW  = RB + 3;
  localparam int LSH = (2 * OUT_FRAC_BITS > 62) ? 2 * OUT_FRAC_BITS - 62 : 0;
  localparam int RSH = (2 * OUT_FRAC_BITS < 62) ? 62 - 2 * OUT_FRAC_BITS : 0;
  localparam logic [UW-1:0]    HALF    = UW'(1) << (UW - 1);
  localparam logic [RB-1:0]    POS_MAX = RB'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [RB-1:0]    NEG_MAG = RB'(64'd1 << (OUT_W - 1));

  logic          sgn1_r, sgn2_r;
  logic [UW-1:0] mag1_r, mag2_r;
  logic [SW-1:0] sq1_r, sq2_r, s_r, n_r;
  logic [NS-1:0] lz_r, sh_r;
  logic [Z_W-1:0] z_r;
  logic [LOG_FRAC-1:0] f_r;
  logic [2*LOG_FRAC:0] pa_r;
  logic [NS:0]   ti_r;
  logic [WW-1:0] w_r;
  logic [SW:0]   rem_r;
  logic [P_W-1:0] quo_r;
  logic [QW-1:0] acc_r;
  logic [SQW-1:0] op_r;
  logic [RW-1:0] srem_r;
  logic [RB-1:0] root_r;
  logic [OUT_W-1:0] spare_r, out_r;

  logic [NS:0]        shamt;
  logic               top_zero;
  logic [SW+30:0]     nz;
  logic [2*Z_W-1:0]   zprod;
  logic [Z_W:0]       zz;
  logic [TW-1:0]      t_v;
  logic               dbit;
  logic [SW:0]        r2;
  logic [SQW-1:0]     q_ext;
  logic [RW-1:0]      rem_sh, trial;
  logic               neg;
  logic [RB-1:0]      mag_sat;
  logic [OUT_W-1:0]   sat_v;

  // Status: reject an empty or out-of-circle pair
  assign stat.reject = (s_r == '0) || (s_r[SW-1:SW-2] != 2'b00);
  assign deviate = out_r;

  // Combinational helpers for the iteration steps
  always_comb begin
    shamt    = (NS+1)'(SW) - (NS+1)'(sh_r);
    top_zero = ((n_r >> shamt) == '0);
    nz       = {n_r, 31'b0};
    zprod    = (2*Z_W)'(z_r) * (2*Z_W)'(z_r);
    zz       = zprod[2*Z_W-1 -: Z_W+1];
    t_v      = (TW'(lz_r - NS'(1)) << LOG_FRAC) - TW'(f_r);
    dbit     = (rem_r >= {1'b0, s_r});
    r2       = dbit ? (rem_r - {1'b0, s_r}) : rem_r;
    q_ext    = SQW'(acc_r);
    q_ext    = (q_ext << LSH) >> RSH;
    rem_sh   = {srem_r[RW-3:0], op_r[SQW-1 -: 2]};
    trial    = RW'({root_r, 2'b01});
    neg      = cmd.second ? sgn2_r : sgn1_r;
    if (neg) begin
      mag_sat = (root_r > NEG_MAG) ? NEG_MAG : root_r;
      sat_v   = OUT_W'(~mag_sat + RB'(1));
    end else begin
      mag_sat = (root_r > POS_MAX) ? POS_MAX : root_r;
      sat_v   = OUT_W'(mag_sat);
    end
  end

  // Execute one command per cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        sgn1_r <= ~uniform_a[UW-1];
        sgn2_r <= ~uniform_b[UW-1];
        mag1_r <= uniform_a[UW-1] ? (uniform_a & ~HALF) : (HALF - uniform_a);
        mag2_r <= uniform_b[UW-1] ? (uniform_b & ~HALF) : (HALF - uniform_b);
      end
      CMD_SQ1: sq1_r <= SW'(mag1_r) * SW'(mag1_r);
      CMD_SQ2: sq2_r <= SW'(mag2_r) * SW'(mag2_r);
      CMD_SUM: s_r <= sq1_r + sq2_r;
      CMD_NINIT: begin
        n_r  <= s_r;
        lz_r <= '0;
        sh_r <= NS'(1) << (NS - 1);
      end
      CMD_NORM: begin
        if (top_zero) begin
          n_r  <= n_r << sh_r;
          lz_r <= lz_r + sh_r;
        end
        sh_r <= sh_r >> 1;
      end
      CMD_ZINIT: begin
        z_r <= nz[SW+30 -: Z_W];
        f_r <= '0;
      end
      CMD_LOG: begin
        if (zz[Z_W]) begin
          z_r <= zz[Z_W:1];
          f_r <= {f_r[LOG_FRAC-2:0], 1'b1};
        end else begin
          z_r <= zz[Z_W-1:0];
          f_r <= {f_r[LOG_FRAC-2:0], 1'b0};
        end
      end
      CMD_W1: begin
        pa_r <= (2*LOG_FRAC+1)'(t_v[LOG_FRAC-1:0]) * (2*LOG_FRAC+1)'(TWO_LN2_Q30);
        ti_r <= t_v[TW-1:LOG_FRAC];
      end
      CMD_W2: w_r <= WW'(WW'(ti_r) * WW'(TWO_LN2_Q30)) + WW'(pa_r >> LOG_FRAC);
      CMD_DIVI: begin
        rem_r <= (SW+1)'(cmd.second ? sq2_r : sq1_r);
        quo_r <= '0;
      end
      CMD_DIV: begin
        rem_r <= {r2[SW-1:0], 1'b0};
        quo_r <= {quo_r[P_W-2:0], dbit};
      end
      CMD_MUL1: acc_r <= QW'(64'(w_r[31:0]) * 64'(quo_r[31:0]));
      CMD_MUL2: acc_r <= acc_r
                        + (QW'(QW'(w_r[WW-1:32]) * QW'(quo_r[31:0])) << 32)
                        + (quo_r[P_W-1] ? (QW'(w_r) << 32) : '0);
      CMD_SQI: begin
        op_r   <= q_ext;
        srem_r <= '0;
        root_r <= '0;
      end
      CMD_SQRT: begin
        if (rem_sh >= trial) begin
          srem_r <= rem_sh - trial;
          root_r <= {root_r[RB-2:0], 1'b1};
        end else begin
          srem_r <= rem_sh;
          root_r <= {root_r[RB-2:0], 1'b0};
        end
        op_r <= op_r << 2;
      end
      CMD_SPARE:     spare_r <= sat_v;
      CMD_OUT_RES:   out_r   <= sat_v;
      CMD_OUT_SPARE: out_r   <= spare_r;
      default: ;
    endcase
  end

endmodule

// ----- design/pgd_ctrl.sv -----
// Controller of the polar Gaussian deviate block: sequences the datapath,
// owns the handshake, the spare flag and the output valid. Uses pgd_pkg.
module pgd_ctrl #(
  parameter int NORM_STEPS = 6,
  parameter int ROOT_STEPS = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pgd_pkg::dp_stat_t stat,
  output pgd_pkg::dp_cmd_t  cmd
);
  import pgd_pkg::*;

  localparam int CNT_MAX = (ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_SQ1   = 18'b000000000000000010,
    ST_SQ2   = 18'b000000000000000100,
    ST_SUM   = 18'b000000000000001000,
    ST_CHK   = 18'b000000000000010000,
    ST_NORM  = 18'b000000000000100000,
    ST_ZINIT = 18'b000000000001000000,
    ST_LOG   = 18'b000000000010000000,
    ST_W1    = 18'b000000000100000000,
    ST_W2    = 18'b000000001000000000,
    ST_DIVI  = 18'b000000010000000000,
    ST_DIV   = 18'b000000100000000000,
    ST_MUL1  = 18'b000001000000000000,
    ST_MUL2  = 18'b000010000000000000,
    ST_SQI   = 18'b000100000000000000,
    ST_SQRT  = 18'b001000000000000000,
    ST_STORE = 18'b010000000000000000,
    ST_DONE  = 18'b100000000000000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sec_r, sec_nxt;
  logic             spare_r, spare_nxt;
  logic             ov_r, ov_nxt;
  logic             out_free;

  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE) && out_free;
  assign out_valid = ov_r;

  // Next state, counters and datapath command
  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    sec_nxt    = sec_r;
    spare_nxt  = spare_r;
    ov_nxt     = ov_r && !out_ready;
    cmd.op     = CMD_NONE;
    cmd.second = sec_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && out_free) begin
          if (spare_r) begin
            cmd.op    = CMD_OUT_SPARE;
            ov_nxt    = 1'b1;
            spare_nxt = 1'b0;
          end else begin
            cmd.op = CMD_LOAD;
            st_nxt = ST_SQ1;
          end
        end
      end
      ST_SQ1: begin
        cmd.op = CMD_SQ1;
        st_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.op = CMD_SQ2;
        st_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = CMD_SUM;
        st_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.op  = CMD_NINIT;
        cnt_nxt = '0;
        st_nxt  = stat.reject ? ST_IDLE : ST_NORM;
      end
      ST_NORM: begin
        cmd.op = CMD_NORM;
        if (cnt_r == CNT_W'(NORM_STEPS - 1)) st_nxt = ST_ZINIT;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_ZINIT: begin
        cmd.op  = CMD_ZINIT;
        cnt_nxt = '0;
        st_nxt  = ST_LOG;
      end
      ST_LOG: begin
        cmd.op = CMD_LOG;
        if (cnt_r == CNT_W'(LOG_STEPS - 1)) st_nxt = ST_W1;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_W1: begin
        cmd.op = CMD_W1;
        st_nxt = ST_W2;
      end
      ST_W2: begin
        cmd.op  = CMD_W2;
        sec_nxt = 1'b0;
        st_nxt  = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.op  = CMD_DIVI;
        cnt_nxt = '0;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = CMD_DIV;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) st_nxt = ST_MUL1;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_MUL1: begin
        cmd.op = CMD_MUL1;
        st_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op = CMD_MUL2;
        st_nxt = ST_SQI;
      end
      ST_SQI: begin
        cmd.op  = CMD_SQI;
        cnt_nxt = '0;
        st_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = CMD_SQRT;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) st_nxt = sec_r ? ST_DONE : ST_STORE;
        else cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_STORE: begin
        cmd.op    = CMD_SPARE;
        spare_nxt = 1'b1;
        sec_nxt   = 1'b1;
        st_nxt    = ST_DIVI;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.op = CMD_OUT_RES;
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      sec_r   <= 1'b0;
      spare_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sec_r   <= sec_nxt;
      spare_r <= spare_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ----- design/polar_gaussian_deviate_core.sv -----
// Polar Gaussian deviate generator, top level.
// Pairs of uniform fractions come in on in_ch (uniform_a, uniform_b); unit
// normal deviates in two's complement Q5.OUT_FRAC_BITS leave on out_ch.
// Each beat is taken when valid and ready are both high.
// A pair inside the unit circle yields one deviate on out_ch and keeps a
// second one as a spare; the next input beat then emits the spare in the
// cycle after it and its pair is dropped. A pair outside the circle, or at
// the center, gives no output beat and returns the block to idle. An
// accepted pair is loaded, squared, summed and checked, then runs NORM_STEPS
// normalize steps, 30 log2 squarings and two steps forming w; then, per
// component, a divide setup, a 33-step divide, two multiply steps, a square
// root setup, ROOT_STEPS square root steps and a store or output step. The
// squaring multiplier, the restoring divider and the square root unit are
// shared one step per cycle, so one pair is in flight at a time.
// in_ch.ready is high only while idle and the output register is empty or
// being read; a stalled receiver holds the result and blocks new input.
// Reset (rst_n low, synchronous) drops the spare and any pending result.
module polar_gaussian_deviate_core #(
  parameter int UNIFORM_BITS  = 24,
  parameter int OUT_FRAC_BITS = 24
) (
  input logic         clk,
  input logic         rst_n,
  pgd_in_if.sink      in_ch,
  pgd_out_if.source   out_ch
);
  import pgd_pkg::*;

  localparam int NS = norm_steps(UNIFORM_BITS);
  localparam int RB = root_bits(UNIFORM_BITS, OUT_FRAC_BITS);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pgd_ctrl #(
    .NORM_STEPS (NS),
    .ROOT_STEPS (RB)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pgd_datapath #(
    .UNIFORM_BITS  (UNIFORM_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .uniform_a (in_ch.uniform_a),
    .uniform_b (in_ch.uniform_b),
    .cmd       (cmd),
    .stat      (stat),
    .deviate   (out_ch.deviate)
  );

endmodule

// ----- design/pgd_checker.sv -----
// Port-level checks for the polar Gaussian deviate block.
// Bound to polar_gaussian_deviate_core; depends on its channel ports only.
module pgd_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] deviate
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(deviate))
    else $error("result changed while stalled");

  // Block input while a result waits
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken with output register full");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the output empty and in_ready low, the next result is not tied to a beat in that cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_ready |=> !(out_valid && $past(in_valid && in_ready)))
    else $error("result tied to a beat that was not taken");

endmodule

bind polar_gaussian_deviate_core pgd_port_checks u_pgd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .deviate   (out_ch.deviate)
);
